// File: design/permuted_radix64_block_decoder_top_assert.svh
// Assertion macros shared by the permuted radix-64 block decoder modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PERMUTED_RADIX64_BLOCK_DECODER_TOP_ASSERT_SVH
`define PERMUTED_RADIX64_BLOCK_DECODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/prbd_pkg.sv
// Package for the permuted radix-64 block decoder: word types, codes and the
// symbol alphabet function. It depends on nothing else.
package prbd_pkg;

	localparam int unsigned BLOCK_BYTES_DEF = 128;
	localparam int unsigned LINE_CHARS_DEF  = 57;
	localparam int unsigned PERM_DEPTH      = 128;
	localparam int unsigned IDX_W           = 7;
	localparam int unsigned COL_W           = 6;
	localparam int unsigned QUEUE_DEPTH     = 4;

	localparam logic [7:0] LINE_MARK = 8'h23;
	localparam logic [7:0] NEWLINE   = 8'h0A;

	localparam logic ACT_PERM = 1'b0;
	localparam logic ACT_CHAR = 1'b1;

	typedef struct packed {
		logic             action;
		logic [IDX_W-1:0] perm_index;
		logic [IDX_W-1:0] perm_value;
		logic [7:0]       text_char;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] dest_index;
		logic [7:0]       byte_value;
		logic             block_done;
	} result_t;

	typedef enum logic {
		CMD_PERM = 1'b0,
		CMD_BYTE = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [IDX_W-1:0] index;
		logic [7:0]       value;
		logic             done;
	} cmd_t;

	function automatic logic [5:0] sym_of(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30 + 8'd26;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd36;
		end else if (c == 8'h2E) begin
			d = 8'd62;
		end else if (c == 8'h2F) begin
			d = 8'd63;
		end
		return d[5:0];
	endfunction

endpackage

// File: design/permuted_radix64_block_decoder_top.sv
// Top level of the permuted radix-64 block decoder.
// Instantiates prbd_front, prbd_queue and prbd_back; uses prbd_pkg.
//
//   channel   direction   handshake                word type
//   item      in          item_valid / item_stall  prbd_pkg::item_t
//   result    out         result_valid / result_stall  prbd_pkg::result_t
//
// One input word is accepted per cycle unless item_stall is high; a decoded
// byte passes through a four-word queue and the registered read of the
// 128-entry permutation table memory before it leaves.
// item_stall is high only while the queue is full; result_stall holds the
// result register and lets the queue fill. Reset clears the line, group and
// byte counters; the permutation table holds no reset value until written.
module permuted_radix64_block_decoder_top #(
	parameter int unsigned BLOCK_BYTES = prbd_pkg::BLOCK_BYTES_DEF,
	parameter int unsigned LINE_CHARS  = prbd_pkg::LINE_CHARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  prbd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output prbd_pkg::result_t result
);

	logic           push;
	logic           full;
	logic           pop;
	logic           head_valid;
	prbd_pkg::cmd_t wr_cmd;
	prbd_pkg::cmd_t head;

	prbd_front #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.LINE_CHARS (LINE_CHARS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.full      (full),
		.push      (push),
		.cmd       (wr_cmd)
	);

	prbd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	prbd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

// File: design/prbd_front.sv
// Front end of the decoder: accepts words, forwards table writes, follows the
// line structure and turns symbols into bytes tagged with their block position. Uses prbd_pkg.
module prbd_front #(
	parameter int unsigned BLOCK_BYTES = prbd_pkg::BLOCK_BYTES_DEF,
	parameter int unsigned LINE_CHARS  = prbd_pkg::LINE_CHARS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  prbd_pkg::item_t item,
	input  logic            full,
	output logic            push,
	output prbd_pkg::cmd_t  cmd
);

	localparam int unsigned BCW = $clog2(BLOCK_BYTES);

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_TAKE  = 4'b0010,
		PH_SKIP  = 4'b0100,
		PH_PAD   = 4'b1000
	} phase_t;

	phase_t                      phase_q, phase_d;
	logic [prbd_pkg::COL_W-1:0]  col_q, col_d;
	logic [1:0]                  grp_q, grp_d;
	logic [5:0]                  prev_q, prev_d;
	logic [BCW-1:0]              bcnt_q, bcnt_d;
	logic                        accept;
	logic                        feed;
	logic                        made;
	logic                        last;
	logic [5:0]                  sym;
	logic [7:0]                  byte_val;
	logic [BCW+prbd_pkg::IDX_W-1:0] bcnt_ext;

	assign accept     = item_valid && !full;
	assign item_stall = full;
	assign bcnt_ext   = {{prbd_pkg::IDX_W{1'b0}}, bcnt_q};

	always_comb begin
		phase_d  = phase_q;
		col_d    = col_q;
		grp_d    = grp_q;
		prev_d   = prev_q;
		bcnt_d   = bcnt_q;
		feed     = 1'b0;
		made     = 1'b0;
		last     = 1'b0;
		byte_val = 8'd0;
		sym      = prbd_pkg::sym_of(item.text_char);

		if (item.action == prbd_pkg::ACT_CHAR) begin
			unique case (phase_q)
				PH_START: begin
					if (item.text_char == prbd_pkg::LINE_MARK) begin
						phase_d = PH_TAKE;
						col_d   = '0;
					end else if (item.text_char != prbd_pkg::NEWLINE) begin
						phase_d = PH_SKIP;
					end
				end
				PH_TAKE: begin
					if (item.text_char == prbd_pkg::NEWLINE) begin
						phase_d = PH_PAD;
					end else begin
						feed = 1'b1;
					end
				end
				PH_PAD: begin
					feed = 1'b1;
					sym  = 6'd0;
				end
				PH_SKIP: begin
					if (item.text_char == prbd_pkg::NEWLINE) begin
						phase_d = PH_START;
					end
				end
				default: begin
					phase_d = PH_START;
				end
			endcase
		end

		if (feed) begin
			case (grp_q)
				2'd1: byte_val = {prev_q, sym[5:4]};
				2'd2: byte_val = {prev_q[3:0], sym[5:2]};
				2'd3: byte_val = {prev_q[1:0], sym};
				default: byte_val = 8'd0;
			endcase
			made   = (grp_q != 2'd0);
			prev_d = sym;
			grp_d  = grp_q + 2'd1;
			if (made) begin
				last   = (bcnt_q == BCW'(BLOCK_BYTES - 1));
				bcnt_d = last ? '0 : bcnt_q + 1'b1;
				if (last) begin
					grp_d  = 2'd0;
					prev_d = 6'd0;
				end
			end
			col_d = col_q + 1'b1;
			if (last || col_q == prbd_pkg::COL_W'(LINE_CHARS - 1)) begin
				col_d   = '0;
				phase_d = (phase_q == PH_TAKE) ? PH_SKIP : PH_START;
			end
		end
	end

	always_comb begin
		if (item.action == prbd_pkg::ACT_PERM) begin
			push       = accept;
			cmd.kind   = prbd_pkg::CMD_PERM;
			cmd.index  = item.perm_index;
			cmd.value  = {1'b0, item.perm_value};
			cmd.done   = 1'b0;
		end else begin
			push       = accept && made;
			cmd.kind   = prbd_pkg::CMD_BYTE;
			cmd.index  = bcnt_ext[prbd_pkg::IDX_W-1:0];
			cmd.value  = byte_val;
			cmd.done   = last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			col_q   <= '0;
			grp_q   <= 2'd0;
			prev_q  <= 6'd0;
			bcnt_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			col_q   <= col_d;
			grp_q   <= grp_d;
			prev_q  <= prev_d;
			bcnt_q  <= bcnt_d;
		end
	end

endmodule

// File: design/prbd_queue.sv
// Short command queue between the front and back ends of the decoder.
// Uses prbd_pkg and the shared assertion macro header.
`include "permuted_radix64_block_decoder_top_assert.svh"

module prbd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  prbd_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output prbd_pkg::cmd_t head
);

	localparam int unsigned QAW = $clog2(prbd_pkg::QUEUE_DEPTH);

	prbd_pkg::cmd_t   entry_q [prbd_pkg::QUEUE_DEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QAW:0]     count_q;

	assign full       = (count_q == (QAW+1)'(prbd_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(prbd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(prbd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PRBD_ASSERT_NOW(a_no_push_when_full, push, !full, "Word pushed into a full queue.")
	`PRBD_ASSERT_NOW(a_no_pop_when_empty, pop, head_valid, "Word popped from an empty queue.")
	`PRBD_ASSERT_NEXT(a_push_grows, push && !pop, count_q == $past(count_q) + 1'b1, "Queue count did not grow on a push.")

endmodule

// File: design/prbd_back.sv
// Back end of the decoder: holds the permutation table memory, looks up the
// destination of each byte and drives the result register. Uses prbd_pkg.
`include "permuted_radix64_block_decoder_top_assert.svh"

module prbd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  prbd_pkg::cmd_t    head,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output prbd_pkg::result_t result
);

	logic [prbd_pkg::IDX_W-1:0] perm_mem [prbd_pkg::PERM_DEPTH];
	logic [prbd_pkg::IDX_W-1:0] dest_q;
	logic [7:0]                 byte_q;
	logic                       done_q;
	logic                       valid_q;

	assign pop          = head_valid && !(valid_q && result_stall);
	assign result_valid = valid_q;
	assign result.dest_index = dest_q;
	assign result.byte_value = byte_q;
	assign result.block_done = done_q;

	always_ff @(posedge clk) begin
		if (pop && head.kind == prbd_pkg::CMD_PERM) begin
			perm_mem[head.index] <= head.value[prbd_pkg::IDX_W-1:0];
		end
		if (pop && head.kind == prbd_pkg::CMD_BYTE) begin
			dest_q <= perm_mem[head.index];
			byte_q <= head.value;
			done_q <= head.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!(valid_q && result_stall)) begin
			valid_q <= head_valid && head.kind == prbd_pkg::CMD_BYTE;
		end
	end

	`PRBD_ASSERT_NEXT(a_byte_pop_shows, pop && head.kind == prbd_pkg::CMD_BYTE, result_valid, "Popped byte did not reach the result register.")
	`PRBD_ASSERT_NEXT(a_perm_pop_silent, pop && head.kind == prbd_pkg::CMD_PERM, !result_valid, "Table write produced a result.")
	`PRBD_ASSERT_NEXT(a_idle_clears, !head_valid && !(result_valid && result_stall), !result_valid, "Result shown without a queued byte.")

endmodule
